// File: hw/rtl/wgwa_pkg.sv
`default_nettype none
package wgwa_pkg;

   // sample and window geometry
   localparam int SAMPLE_W     = 16;
   localparam int WINDOW_DEPTH = 8;
   localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

   // q1.16 weights, the integer bit is needed only for 1.0
   localparam int WEIGHT_W   = 17;
   localparam int FRAC_W     = 16;
   localparam int WSUM_W     = WEIGHT_W + $clog2(WINDOW_DEPTH + 1);
   localparam int PROD_W     = SAMPLE_W + WEIGHT_W;
   // acc < 2^16 * wsum, so it fits in sample plus weight-sum bits
   localparam int ACC_W      = SAMPLE_W + WSUM_W;
   localparam int DIV_CNT_W  = $clog2(SAMPLE_W);

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);
   localparam logic [FRAC_W-1:0]   DECAY_Q16  = FRAC_W'(45875);

   typedef logic [WEIGHT_W-1:0] weight_array_type [WINDOW_DEPTH];
   typedef logic [WSUM_W-1:0]   wsum_array_type   [WINDOW_DEPTH];

   // weight of the sample k steps older than the newest, truncated decay
   function automatic weight_array_type build_weights();
      weight_array_type tbl;
      logic [WEIGHT_W+FRAC_W-1:0] prod;
      logic [WEIGHT_W-1:0] w;
      w = WEIGHT_ONE;
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
         tbl[k] = w;
         prod   = (WEIGHT_W+FRAC_W)'(w) * (WEIGHT_W+FRAC_W)'(DECAY_Q16);
         w      = prod[FRAC_W +: WEIGHT_W];
      end
      return tbl;
   endfunction

   // sum of weights for a fill count of k+1
   function automatic wsum_array_type build_wsums();
      wsum_array_type tbl;
      weight_array_type wt;
      logic [WSUM_W-1:0] s;
      wt = build_weights();
      s  = '0;
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
         s      = s + WSUM_W'(wt[k]);
         tbl[k] = s;
      end
      return tbl;
   endfunction

   localparam weight_array_type WEIGHT_TABLE = build_weights();
   localparam wsum_array_type   WSUM_TABLE   = build_wsums();

endpackage
`default_nettype wire

// File: hw/rtl/windowed_geometric_weighted_average_core.sv
// one item is worked on at a time: req_tready is high only in idle, so no item is accepted
// until the last result is loaded into the output register; one shared multiply-accumulate
// steps over the held samples (fill_count is 1 to 8), then a restoring divider produces one quotient bit per cycle
// the output register lets a new item be accepted while a result waits to be taken
// reset: synchronous active high; clears the sequencer, window store, fill count,
// write pointer and rsp_tvalid
`default_nettype none
module windowed_geometric_weighted_average_core (
   input  wire  logic                          clock,
   input  wire  logic                          reset,
   input  wire  logic                          req_tvalid,
   output logic                                req_tready,
   input  wire  logic [wgwa_pkg::SAMPLE_W-1:0] req_tdata,   // [15:0] sample
   output logic                                rsp_tvalid,
   input  wire  logic                          rsp_tready,
   output logic [wgwa_pkg::SAMPLE_W-1:0]       rsp_tdata    // [15:0] average
);
   import wgwa_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MAC  = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [SAMPLE_W-1:0]  window_ff [WINDOW_DEPTH];

   logic [2:0]           state_ff, state_in;
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]     tap_ff, tap_in;
   logic [CNT_W-1:0]     fill_count_ff, fill_count_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [WSUM_W-1:0]    wsum_ff, wsum_in;
   logic [WSUM_W-1:0]    rem_ff, rem_in;
   logic [SAMPLE_W-1:0]  quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [SAMPLE_W-1:0]  avg_ff, avg_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 req_fire;
   logic                 out_free;
   logic [PROD_W-1:0]    product;
   logic [WSUM_W:0]      shifted;
   logic [WSUM_W:0]      trial;
   logic                 last_tap;
   logic [PTR_W-1:0]     fill_idx;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = avg_ff;

   // shared multiplier: one held sample times its weight
   assign product  = PROD_W'(window_ff[rd_ptr_ff]) * PROD_W'(WEIGHT_TABLE[tap_ff]);
   assign fill_idx = PTR_W'(fill_count_ff - CNT_W'(1));
   assign last_tap = (tap_ff == fill_idx);

   // restoring division step: bring in the next dividend bit and try a subtract
   assign shifted = {rem_ff, quo_ff[SAMPLE_W-1]};
   assign trial   = shifted - {1'b0, wsum_ff};

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      tap_in        = tap_ff;
      fill_count_in = fill_count_ff;
      acc_in        = acc_ff;
      wsum_in       = wsum_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      avg_in        = avg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rd_ptr_in = wr_ptr_ff;
               wr_ptr_in = (wr_ptr_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + PTR_W'(1);
               if (fill_count_ff != CNT_W'(WINDOW_DEPTH)) begin
                  fill_count_in = fill_count_ff + CNT_W'(1);
               end
               tap_in   = '0;
               acc_in   = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            // walk from the newest sample back to the oldest one held
            acc_in    = acc_ff + ACC_W'(product);
            rd_ptr_in = (rd_ptr_ff == '0) ? PTR_W'(WINDOW_DEPTH - 1) : rd_ptr_ff - PTR_W'(1);
            tap_in    = tap_ff + PTR_W'(1);
            if (last_tap) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // high part is already below wsum, so the quotient fits 16 bits
            rem_in     = acc_ff[ACC_W-1 -: WSUM_W];
            quo_in     = acc_ff[SAMPLE_W-1:0];
            wsum_in    = WSUM_TABLE[fill_idx];
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (!trial[WSUM_W]) begin
               rem_in = trial[WSUM_W-1:0];
            end else begin
               rem_in = shifted[WSUM_W-1:0];
            end
            quo_in     = {quo_ff[SAMPLE_W-2:0], !trial[WSUM_W]};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(SAMPLE_W - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // quotient never exceeds the largest held sample, no clamp needed
            if (out_free) begin
               avg_in       = quo_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // window store, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
      end else if (req_fire) begin
         window_ff[wr_ptr_ff] <= req_tdata;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_ptr_ff     <= '0;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_ptr_ff     <= wr_ptr_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rd_ptr_ff  <= rd_ptr_in;
      tap_ff     <= tap_in;
      acc_ff     <= acc_in;
      wsum_ff    <= wsum_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      div_cnt_ff <= div_cnt_in;
      avg_ff     <= avg_in;
   end

`ifndef SYNTHESIS
   // the window is never empty while an item is being worked on
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (fill_count_ff != '0 &&
                                 fill_count_ff <= CNT_W'(WINDOW_DEPTH)))
      else $error("fill count out of range during processing");

   // partial remainder stays below the divisor through the division
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < wsum_ff))
      else $error("divider remainder not below weight sum");

   // an accepted item always starts the multiply-accumulate pass
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_MAC))
      else $error("accepted item did not start accumulation");

   // a new result only appears out of the finish step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN))
      else $error("result raised outside finish step");
`endif

endmodule
`default_nettype wire
